// ----- src/mpt_pkg.sv -----
package mpt_pkg;

    // Table depth default
    localparam int SLOTS_DEF = 64;

    // Field widths
    localparam int SLOT_FW = 6;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 16;
    localparam int POL_W   = 2;

    // Stream widths
    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // Request tdata bit offsets
    localparam int OFS_SLOT = 0;
    localparam int OFS_RUN  = 6;
    localparam int OFS_CT   = 7;
    localparam int OFS_HINT = 39;
    localparam int OFS_REM  = 71;
    localparam int OFS_ID   = 103;

    // tuser bit positions
    localparam int SU_CMD   = 0;
    localparam int MU_FOUND = 0;
    localparam int MU_FELL  = 1;

    // Request kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PICK  = 1'b1;

    // Pick policies
    typedef logic [POL_W-1:0] policy_t;
    localparam policy_t POL_RR   = 2'd0;
    localparam policy_t POL_FIFO = 2'd1;
    localparam policy_t POL_SJF  = 2'd2;
    localparam policy_t POL_STCF = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_BEST,
        ST_SCAN_RR,
        ST_RESP
    } state_t;

    // One slot of the task table (runnable flag kept apart)
    typedef struct packed {
        logic [TIME_W-1:0] ctime;
        logic [TIME_W-1:0] hint;
        logic [TIME_W-1:0] rem;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_en;
        logic scan_clr;
        logic scan_rr;
        logic scan_run;
        logic eval_best;
        logic best_clr;
        logic res_clr;
        logic res_load_best;
        logic res_load_rr;
        logic fell;
        logic ptr_upd;
        logic out_load;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic    scan_done;
        logic    best_found;
        logic    rr_hit;
        logic    out_free;
        policy_t policy;
    } ctl_sts_t;

endpackage

// ----- src/mpt_ctrl.sv -----
module mpt_ctrl import mpt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_cmd,
    output logic     s_tready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.res_clr = 1'b1;
                    if (s_cmd == CMD_WRITE) begin
                        cmd.wr_en  = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        cmd.best_clr = 1'b1;
                        cmd.scan_clr = 1'b1;
                        cmd.scan_rr  = (sts.policy == POL_RR);
                        state_next   = (sts.policy == POL_RR) ? ST_SCAN_RR : ST_SCAN_BEST;
                    end
                end
            end
            ST_SCAN_BEST: begin
                cmd.scan_run  = 1'b1;
                cmd.eval_best = 1'b1;
                if (sts.scan_done) begin
                    if (sts.best_found) begin
                        cmd.res_load_best = 1'b1;
                        state_next        = ST_RESP;
                    end else if (sts.policy inside {POL_SJF, POL_STCF}) begin
                        // no hinted task: fall back to round robin
                        cmd.scan_clr = 1'b1;
                        cmd.scan_rr  = 1'b1;
                        state_next   = ST_SCAN_RR;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN_RR: begin
                cmd.scan_run = 1'b1;
                if (sts.rr_hit) begin
                    cmd.res_load_rr = 1'b1;
                    cmd.ptr_upd     = 1'b1;
                    cmd.fell        = (sts.policy != POL_RR);
                    state_next      = ST_RESP;
                end else if (sts.scan_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/mpt_dpath.sv -----
module mpt_dpath import mpt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [POL_W-1:0]     cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    input  ctl_cmd_t             cmd,
    output ctl_sts_t             sts
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = SLOT_W + 1;
    localparam int EXT_W  = SLOT_W + SLOT_FW;
    localparam int M_PAD  = M_TDATA_W - SLOT_FW - ID_W;

    localparam logic [SUM_W-1:0]  SLOTS_S   = SUM_W'(SLOTS);
    localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [EXT_W-1:0]  SLOTS_E   = EXT_W'(SLOTS);

    // Request fields
    logic [SLOT_FW-1:0] in_slot;
    logic               in_run;
    entry_t             wr_entry;

    assign in_slot        = s_tdata[OFS_SLOT +: SLOT_FW];
    assign in_run         = s_tdata[OFS_RUN];
    assign wr_entry.ctime = s_tdata[OFS_CT +: TIME_W];
    assign wr_entry.hint  = s_tdata[OFS_HINT +: TIME_W];
    assign wr_entry.rem   = s_tdata[OFS_REM +: TIME_W];
    assign wr_entry.id    = s_tdata[OFS_ID +: ID_W];

    // Write address, slots past the table are dropped
    logic [EXT_W-1:0]  wr_slot_ext;
    logic [SLOT_W-1:0] wr_addr;
    logic              wr_go;

    assign wr_slot_ext = {{SLOT_W{1'b0}}, in_slot};
    assign wr_addr     = wr_slot_ext[SLOT_W-1:0];
    assign wr_go       = cmd.wr_en && (wr_slot_ext < SLOTS_E);

    // Policy register
    policy_t policy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_RR;
        end else if (cfg_we) begin
            policy_reg <= cfg_wdata;
        end
    end

    // Scan counter and read address
    logic [CNT_W-1:0]  cnt_reg;
    logic              rr_mode_reg;
    logic              p1_valid_reg;
    logic [SLOT_W-1:0] p1_idx_reg;
    logic [SLOT_W-1:0] ptr_reg;
    logic [SUM_W-1:0]  scan_sum;
    logic [SUM_W-1:0]  scan_wrap;
    logic [SLOT_W-1:0] rd_addr;
    logic              issue;

    assign issue     = cmd.scan_run && (cnt_reg != CNT_END);
    assign scan_sum  = (rr_mode_reg ? {1'b0, ptr_reg} : '0) + SUM_W'(cnt_reg);
    assign scan_wrap = scan_sum - SLOTS_S;
    assign rd_addr   = (scan_sum >= SLOTS_S) ? scan_wrap[SLOT_W-1:0] : scan_sum[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            rr_mode_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
        end else if (cmd.scan_clr) begin
            cnt_reg      <= '0;
            rr_mode_reg  <= cmd.scan_rr;
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue;
            if (issue) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            p1_idx_reg <= rd_addr;
        end
    end

    // Slot table: one write port, one registered read port
    entry_t mem [SLOTS];
    entry_t rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (wr_go) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    // Runnable flags, cleared by reset
    logic [SLOTS-1:0] ready_reg;
    logic             rd_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= '0;
        end else if (wr_go) begin
            ready_reg[wr_addr] <= in_run;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ready_reg <= ready_reg[rd_addr];
    end

    // Candidate compare against best so far
    logic [TIME_W-1:0] cand_key;
    logic              cand_ok;
    logic              cand_beats;
    logic              best_found_reg;
    logic [TIME_W-1:0] best_key_reg;
    logic [TIME_W-1:0] best_ct_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [SLOT_W-1:0] best_slot_reg;

    always_comb begin
        case (policy_reg)
            POL_FIFO: cand_key = rd_entry_reg.ctime;
            POL_SJF:  cand_key = rd_entry_reg.hint;
            default:  cand_key = rd_entry_reg.rem;
        endcase
    end

    assign cand_ok    = p1_valid_reg && rd_ready_reg
                        && ((policy_reg == POL_FIFO) || (rd_entry_reg.hint != '0));
    // strict wins keep the lower slot on a full tie
    assign cand_beats = !best_found_reg
                        || (cand_key < best_key_reg)
                        || ((cand_key == best_key_reg)
                            && ((rd_entry_reg.ctime < best_ct_reg)
                                || ((rd_entry_reg.ctime == best_ct_reg)
                                    && (rd_entry_reg.id < best_id_reg))));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
        end else if (cmd.best_clr) begin
            best_found_reg <= 1'b0;
        end else if (cmd.eval_best && cand_ok && cand_beats) begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval_best && cand_ok && cand_beats) begin
            best_key_reg  <= cand_key;
            best_ct_reg   <= rd_entry_reg.ctime;
            best_id_reg   <= rd_entry_reg.id;
            best_slot_reg <= p1_idx_reg;
        end
    end

    // Round-robin pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (cmd.ptr_upd) begin
            ptr_reg <= (p1_idx_reg == LAST_SLOT) ? '0 : p1_idx_reg + SLOT_W'(1);
        end
    end

    // Result stage
    logic              res_found_reg;
    logic              res_fell_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [ID_W-1:0]   res_id_reg;

    always_ff @(posedge aclk) begin
        if (cmd.res_clr) begin
            res_found_reg <= 1'b0;
            res_fell_reg  <= 1'b0;
            res_slot_reg  <= '0;
            res_id_reg    <= '0;
        end else if (cmd.res_load_best) begin
            res_found_reg <= 1'b1;
            res_fell_reg  <= 1'b0;
            res_slot_reg  <= best_slot_reg;
            res_id_reg    <= best_id_reg;
        end else if (cmd.res_load_rr) begin
            res_found_reg <= 1'b1;
            res_fell_reg  <= cmd.fell;
            res_slot_reg  <= p1_idx_reg;
            res_id_reg    <= rd_entry_reg.id;
        end
    end

    // Output register
    logic [EXT_W-1:0]   res_slot_ext;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic               out_fell_reg;
    logic [SLOT_FW-1:0] out_slot_reg;
    logic [ID_W-1:0]    out_id_reg;

    assign res_slot_ext = {{SLOT_FW{1'b0}}, res_slot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_found_reg <= res_found_reg;
            out_fell_reg  <= res_fell_reg;
            out_slot_reg  <= res_slot_ext[SLOT_FW-1:0];
            out_id_reg    <= res_id_reg;
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = {{M_PAD{1'b0}}, out_id_reg, out_slot_reg};
    assign m_tuser[MU_FOUND] = out_found_reg;
    assign m_tuser[MU_FELL]  = out_fell_reg;

    // Status
    assign sts.scan_done  = (cnt_reg == CNT_END) && !p1_valid_reg;
    assign sts.best_found = best_found_reg;
    assign sts.rr_hit     = p1_valid_reg && rd_ready_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;
    assign sts.policy     = policy_reg;

endmodule

// ----- src/multi_policy_task_picker.sv -----
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: slot, runnable, create_time, runtime_hint,
//                                   remaining, task_id; s_tuser: cmd
// m_        out  m_tvalid/m_tready  m_tdata: chosen_slot, chosen_id; m_tuser: found, fell_back
// cfg_      in   cfg_we             cfg_wdata: policy
//
// One request at a time. A write goes to the result state, then to the output register.
// A pick reads the slot table one slot per cycle through its single read port:
// round robin stops at the next runnable slot from the pointer; FIFO, SJF and STCF
// scan every slot; a fallback to round robin adds a second scan from the pointer.
// Reset clears the runnable flags, the round-robin pointer and the policy (round robin);
// no clearing pass. A result held by m_tready low stalls the next result, not the accept.
module multi_policy_task_picker import mpt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config
    input  logic                 cfg_we,
    input  logic [POL_W-1:0]     cfg_wdata,     // policy
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // slot, runnable, create_time, runtime_hint,
                                                // remaining, task_id, pad
    input  logic [S_TUSER_W-1:0] s_tuser,       // cmd
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // chosen_slot, chosen_id, pad
    output logic [M_TUSER_W-1:0] m_tuser        // found, fell_back
);

    ctl_cmd_t ctl_cmd;
    ctl_sts_t ctl_sts;

    mpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser[SU_CMD]),
        .s_tready (s_tready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    mpt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (ctl_cmd),
        .sts       (ctl_sts)
    );

    // fallback is only reported on a successful pick
    a_fell_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[MU_FELL] |-> m_tuser[MU_FOUND])
        else $error("fell_back without found");

    // empty results carry zero slot and id
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[MU_FOUND] |-> (m_tdata == '0))
        else $error("empty result with nonzero payload");

    // an accepted request makes the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

endmodule
